[sv/pwlcf_pkg.sv]
`timescale 1ns / 1ps

package pwlcf_pkg;

  // Default number of breakpoints that the lookup may use.
  localparam int unsigned MAX_ENTRIES_DEF = 8;

  // Field widths.
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned FRIC_W  = 16;
  localparam int unsigned BP_W    = COLOR_W + FRIC_W;

  // Configuration port.
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned PAIR_W     = 2 * BP_W;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned NUM_PAIRS  = 4;

  localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAIR_01     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAIR_23     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PAIR_45     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PAIR_67     = 3'd4;

  // Divider datapath: the dividend is at most 254 * 65535, below 2^24.
  localparam int unsigned QUOT_W  = 24;
  localparam int unsigned DEN_W   = 8;
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned NORM_SHIFT = 12;
  localparam logic [DEN_W-1:0] NORM_DEN = 8'd255;

  // Request to the divide-and-accumulate back end.
  typedef struct packed {
    logic [QUOT_W-1:0] x;
    logic [DEN_W-1:0]  den;
    logic              neg;
    logic [FRIC_W-1:0] base;
  } div_req_t;

endpackage

[sv/pwlcf_div.sv]
`timescale 1ns / 1ps

module pwlcf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  pwlcf_pkg::div_req_t         req_i,
  output logic                        res_valid_o,
  output logic [pwlcf_pkg::FRIC_W-1:0] res_o
);
  import pwlcf_pkg::*;

  localparam int unsigned TabDepth = 1 << DEN_W;
  localparam int unsigned ProdW    = QUOT_W + RECIP_W;

  // Rounded-up reciprocals 2^32/d; exact floor division for dividends below 2^24.
  logic [RECIP_W-1:0] recip [TabDepth];

  for (genvar d = 0; d < TabDepth; d++) begin : g_recip
    localparam logic [63:0] RecipVal = (d < 2) ? 64'd0 :
        (((64'd1 << RECIP_W) + 64'(d) - 64'd1) / 64'((d < 2) ? 1 : d));
    assign recip[d] = RecipVal[RECIP_W-1:0];
  end

  logic [ProdW-1:0]  prod;
  logic [QUOT_W-1:0] quot;

  logic              qa_valid_q;
  logic [QUOT_W-1:0] qa_quot_q;
  logic              qa_neg_q;
  logic [FRIC_W-1:0] qa_base_q;

  logic              out_valid_q;
  logic [FRIC_W-1:0] out_fric_q;
  logic [FRIC_W-1:0] out_fric_d;

  always_comb begin
    prod = {{RECIP_W{1'b0}}, req_i.x} * {{QUOT_W{1'b0}}, recip[req_i.den]};
    if (req_i.den == DEN_W'(1)) begin
      quot = req_i.x;
    end else begin
      quot = prod[ProdW-1:RECIP_W];
    end
  end

  always_comb begin
    if (qa_neg_q) begin
      out_fric_d = qa_base_q - qa_quot_q[FRIC_W-1:0];
    end else begin
      out_fric_d = qa_base_q + qa_quot_q[FRIC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      qa_valid_q  <= req_valid_i;
      out_valid_q <= qa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    qa_quot_q  <= quot;
    qa_neg_q   <= req_i.neg;
    qa_base_q  <= req_i.base;
    out_fric_q <= out_fric_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_fric_q;

endmodule

[sv/piecewise_linear_color_to_friction.sv]
`timescale 1ns / 1ps
// A result appears on friction_o with done_o once the item has passed every stage of the pipeline.
// Throughput: one item per cycle; busy stays low, so start may be held high every cycle.
// The receiver cannot stall, and every accepted item gives exactly one result.
// Reset is asynchronous and active low; it clears the pipeline valid bits and all
// configuration registers, which selects the normalized color result.
module piecewise_linear_color_to_friction #(
  parameter int unsigned MAX_ENTRIES = pwlcf_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pwlcf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pwlcf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pwlcf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  logic [pwlcf_pkg::COLOR_W-1:0]    color_value_i,
  output logic                             done_o,
  output logic [pwlcf_pkg::FRIC_W-1:0]     friction_o
);
  import pwlcf_pkg::*;

  // The pipeline has five register stages:
  //   stage 1: the first half of the interval-halving search, straight off the input;
  //   stage 2: the rest of the search and the fetch of the bounding breakpoints;
  //   stage 3: the interpolation numerator (color offset times friction step);
  //   stage 4: division by the color span as a multiply with a reciprocal table;
  //   stage 5: the signed accumulate onto the lower friction (output register).
  // Each search step compares 8-bit colors only, so two of them fit in one stage.

  localparam int unsigned IdxW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned Iters  = IdxW + 1;
  localparam int unsigned ItersA = (Iters + 1) / 2;
  localparam int unsigned ItersB = Iters - ItersA;

  typedef struct packed {
    logic [IdxW-1:0] lo;
    logic [IdxW-1:0] hi;
    logic            done;
    logic            interp;
  } srch_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Each register is 48 bits at most, so registers sit
  // on 8-byte boundaries and the index is the upper address bits.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] cnt_q;
  logic [PAIR_W-1:0]  pair_q [NUM_PAIRS];
  logic               cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int p = 0; p < NUM_PAIRS; p++) begin
        pair_q[p] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ENTRY_COUNT: cnt_q     <= pwdata[COUNT_W-1:0];
        REG_PAIR_01:     pair_q[0] <= pwdata[PAIR_W-1:0];
        REG_PAIR_23:     pair_q[1] <= pwdata[PAIR_W-1:0];
        REG_PAIR_45:     pair_q[2] <= pwdata[PAIR_W-1:0];
        REG_PAIR_67:     pair_q[3] <= pwdata[PAIR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ENTRY_COUNT: prdata = CFG_DATA_W'(cnt_q);
      REG_PAIR_01:     prdata = CFG_DATA_W'(pair_q[0]);
      REG_PAIR_23:     prdata = CFG_DATA_W'(pair_q[1]);
      REG_PAIR_45:     prdata = CFG_DATA_W'(pair_q[2]);
      REG_PAIR_67:     prdata = CFG_DATA_W'(pair_q[3]);
      default:         prdata = '0;
    endcase
  end

  // Breakpoint e: color in the low byte, friction above, two to a pair register.
  logic [COLOR_W-1:0] bp_color [MAX_ENTRIES];
  logic [FRIC_W-1:0]  bp_fric  [MAX_ENTRIES];

  for (genvar e = 0; e < MAX_ENTRIES; e++) begin : g_bp
    assign bp_color[e] = pair_q[e / 2][(e % 2) * BP_W +: COLOR_W];
    assign bp_fric[e]  = pair_q[e / 2][(e % 2) * BP_W + COLOR_W +: FRIC_W];
  end

  // A count above the supported number of breakpoints saturates.
  logic            norm_mode;
  logic [IdxW-1:0] top_idx;

  assign norm_mode = (cnt_q == '0);
  assign top_idx   = (cnt_q >= COUNT_W'(MAX_ENTRIES)) ? IdxW'(MAX_ENTRIES - 1)
                                                      : IdxW'(cnt_q - COUNT_W'(1));

  // One step of the interval-halving search. The upper bound is tested first,
  // then the lower bound, then the midpoint split. A finished search that
  // returns a breakpoint's friction leaves that breakpoint in hi; a finished
  // search that interpolates leaves the neighboring pair in lo and hi.
  function automatic srch_t srch_step(srch_t s, logic [COLOR_W-1:0] c);
    srch_t           r;
    logic [IdxW-1:0] mid;
    r   = s;
    mid = s.lo + ((s.hi - s.lo) >> 1);
    if (!s.done) begin
      if ((s.hi == s.lo) || (bp_color[s.hi] <= c)) begin
        r.done = 1'b1;
      end else if (bp_color[s.lo] >= c) begin
        r.done = 1'b1;
        r.hi   = s.lo;
      end else if ((mid != s.lo) && (mid != s.hi)) begin
        if (bp_color[mid] > c) begin
          r.hi = mid;
        end else begin
          r.lo = mid;
        end
      end else begin
        r.done   = 1'b1;
        r.interp = 1'b1;
      end
    end
    return r;
  endfunction

  // busy never rises: the pipeline takes an item in every cycle.
  logic in_acc;
  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: first search steps on the incoming color.
  // ---------------------------------------------------------------------------
  srch_t srch_a;

  always_comb begin
    srch_a = '{lo: '0, hi: top_idx, done: 1'b0, interp: 1'b0};
    for (int k = 0; k < ItersA; k++) begin
      srch_a = srch_step(srch_a, color_value_i);
    end
  end

  logic               s1_valid_q;
  logic [COLOR_W-1:0] s1_color_q;
  srch_t              s1_srch_q;
  logic               s1_norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_color_q <= color_value_i;
    s1_srch_q  <= srch_a;
    s1_norm_q  <= norm_mode;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: remaining search steps and fetch of the bounding breakpoints.
  // ---------------------------------------------------------------------------
  srch_t srch_b;

  always_comb begin
    srch_b = s1_srch_q;
    for (int k = 0; k < ItersB; k++) begin
      srch_b = srch_step(srch_b, s1_color_q);
    end
  end

  logic               s2_valid_q;
  logic [COLOR_W-1:0] s2_color_q;
  logic               s2_norm_q;
  logic               s2_interp_q;
  logic [COLOR_W-1:0] s2_cl_q;
  logic [COLOR_W-1:0] s2_ch_q;
  logic [FRIC_W-1:0]  s2_base_q;
  logic [FRIC_W-1:0]  s2_fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_color_q  <= s1_color_q;
    s2_norm_q   <= s1_norm_q;
    s2_interp_q <= srch_b.interp;
    s2_cl_q     <= bp_color[srch_b.lo];
    s2_ch_q     <= bp_color[srch_b.hi];
    s2_base_q   <= srch_b.interp ? bp_fric[srch_b.lo] : bp_fric[srch_b.hi];
    s2_fh_q     <= bp_fric[srch_b.hi];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: numerator and divisor. All three cases share the divider: the
  // normalized result divides color * 4096 by 255 onto zero, an exact hit
  // divides zero by one onto the breakpoint's friction, and an interpolation
  // divides |offset * step| by the color span, with the sign applied after the
  // division so that the quotient truncates toward zero.
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] dcol;
  logic [FRIC_W:0]    dfric;
  logic [FRIC_W:0]    dfric_neg;
  logic [FRIC_W-1:0]  dmag;
  div_req_t           req_d;
  div_req_t           s3_req_q;
  logic               s3_valid_q;

  always_comb begin
    dcol      = s2_color_q - s2_cl_q;
    dfric     = {1'b0, s2_fh_q} - {1'b0, s2_base_q};
    dfric_neg = -dfric;
    dmag      = dfric[FRIC_W] ? dfric_neg[FRIC_W-1:0] : dfric[FRIC_W-1:0];
    if (s2_norm_q) begin
      req_d.x    = QUOT_W'({s2_color_q, {NORM_SHIFT{1'b0}}});
      req_d.den  = NORM_DEN;
      req_d.neg  = 1'b0;
      req_d.base = '0;
    end else if (s2_interp_q) begin
      req_d.x    = QUOT_W'(dcol) * QUOT_W'(dmag);
      req_d.den  = s2_ch_q - s2_cl_q;
      req_d.neg  = dfric[FRIC_W];
      req_d.base = s2_base_q;
    end else begin
      req_d.x    = '0;
      req_d.den  = DEN_W'(1);
      req_d.neg  = 1'b0;
      req_d.base = s2_base_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_req_q <= req_d;
  end

  // ---------------------------------------------------------------------------
  // Stages 4 and 5: reciprocal multiply and accumulate.
  // ---------------------------------------------------------------------------
  pwlcf_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s3_valid_q),
    .req_i       (s3_req_q),
    .res_valid_o (done_o),
    .res_o       (friction_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_acc |-> ##5 done_o)
    else $error("accepted item did not produce a result after five cycles");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o |-> $past(in_acc, 5))
    else $error("result strobe without an item accepted five cycles earlier");

  a_search_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s1_valid_q && !s1_norm_q) |-> srch_b.done)
    else $error("breakpoint search did not finish within the pipeline");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      s3_valid_q |-> (s3_req_q.den != '0))
    else $error("divider received a zero color span");

endmodule
